// ===== rtl/ted_pkg.sv =====
// ----------------------------------------------------------------------------
// ted_pkg: text encoding detector definitions
// Shared encoding codes and byte-mark constants.
// ----------------------------------------------------------------------------
package ted_pkg;

   localparam int CodeWidth = 3;
   localparam int ByteWidth = 8;
   localparam int HeadBytes = 4;
   localparam int HeadWidth = HeadBytes * ByteWidth;
   localparam int CountWidth = $clog2(HeadBytes + 1);

   typedef logic [CodeWidth-1:0]  code_type;
   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [CountWidth-1:0] count_type;

   // Encoding codes on the result port
   localparam code_type CODE_UTF8    = 3'd0;
   localparam code_type CODE_UTF16LE = 3'd1;
   localparam code_type CODE_UTF16BE = 3'd2;
   localparam code_type CODE_UTF32LE = 3'd3;
   localparam code_type CODE_UTF32BE = 3'd4;
   localparam code_type CODE_EUCKR   = 3'd5;
   localparam code_type CODE_SYSTEM  = 3'd6;

   // Byte-order-mark bytes
   localparam byte_type BOM_EF = 8'hEF;
   localparam byte_type BOM_BB = 8'hBB;
   localparam byte_type BOM_BF = 8'hBF;
   localparam byte_type BOM_FF = 8'hFF;
   localparam byte_type BOM_FE = 8'hFE;
   localparam byte_type BOM_00 = 8'h00;

   // EUC-KR pairing limits
   localparam byte_type EUC_LEAD_MIN  = 8'h81;
   localparam byte_type EUC_TRAIL_MIN = 8'h41;
   localparam byte_type HIGH_BYTE_MIN = 8'h80;

   localparam count_type COUNT_FULL = count_type'(HeadBytes);

endpackage

// ===== rtl/text_encoding_detector.sv =====
// ----------------------------------------------------------------------------
// text_encoding_detector: byte-stream text encoding classifier
// Scans one sample byte by byte (UTF-8 structure, EUC-KR pairing, BOM) and
// gives one encoding code on the final byte of each sample.
// ----------------------------------------------------------------------------
// Final byte path: input stage register, then result register, then rsp_.
// Throughput: one byte per cycle unless a final byte stalls; the per-byte check
//    logic sits between the input stage register and the result register.
// A staged byte that does not end a sample never waits; a staged final byte
//    waits only while the result register holds a code that is still stalled.
// Reset (synchronous, active high) empties both registers and returns the
//    scan state to the start of a sample.
module text_encoding_detector import ted_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   // input byte channel
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [7:0]     req_data_byte,
   input  logic           req_end_of_sample,
   // result channel
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [2:0]     rsp_encoding_code
);

   // ------------------------------------------------------------------
   // Input stage register
   // ------------------------------------------------------------------
   logic      s1_valid_ff, s1_valid_in;
   byte_type  s1_byte_ff;
   logic      s1_last_ff;
   logic      s1_advance;
   logic      out_free;

   // Result register
   logic      rsp_valid_ff, rsp_valid_in;
   code_type  rsp_code_ff, rsp_code_in;

   // Scan state for the current sample
   logic [HeadWidth-1:0] head_ff, head_in;
   count_type            seen_ff, seen_in;
   logic [1:0]           cont_due_ff, cont_due_in;
   logic                 utf8_ok_ff, utf8_ok_in;
   logic                 trail_due_ff, trail_due_in;
   logic                 pair_ok_ff, pair_ok_in;

   // Updated state after the staged byte, before end-of-sample clearing
   logic [HeadWidth-1:0] head_upd;
   count_type            seen_upd;
   logic [1:0]           cont_upd;
   logic                 utf8_upd;
   logic                 trail_upd;
   logic                 pair_upd;
   byte_type             b0, b1, b2, b3;
   code_type             code_now;

   // A result register slot frees up when it is empty or being taken.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // Middle bytes produce no word, so they always move on; a final byte
   // needs room in the result register.
   assign s1_advance = s1_valid_ff && (out_free || !s1_last_ff);
   assign req_stall  = s1_valid_ff && !s1_advance;

   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   // ------------------------------------------------------------------
   // Per-byte checks
   // ------------------------------------------------------------------
   always_comb begin
      // capture the first four bytes for BOM matching
      head_upd = head_ff;
      seen_upd = seen_ff;
      if (seen_ff < COUNT_FULL) begin
         case (seen_ff[1:0])
            2'd0:    head_upd[7:0]   = s1_byte_ff;
            2'd1:    head_upd[15:8]  = s1_byte_ff;
            2'd2:    head_upd[23:16] = s1_byte_ff;
            2'd3:    head_upd[31:24] = s1_byte_ff;
            default: head_upd = head_ff;
         endcase
         seen_upd = seen_ff + count_type'(1);
      end

      // UTF-8 structure: count pending continuation bytes
      cont_upd = cont_due_ff;
      utf8_upd = utf8_ok_ff;
      if (utf8_ok_ff) begin
         if (cont_due_ff != 2'd0) begin
            if (s1_byte_ff[7:6] != 2'b10) begin
               utf8_upd = 1'b0;
            end else begin
               cont_upd = cont_due_ff - 2'd1;
            end
         end else if (!s1_byte_ff[7]) begin
            cont_upd = 2'd0;
         end else if (s1_byte_ff inside {[8'hC0:8'hDF]}) begin
            cont_upd = 2'd1;
         end else if (s1_byte_ff inside {[8'hE0:8'hEF]}) begin
            cont_upd = 2'd2;
         end else if (s1_byte_ff inside {[8'hF0:8'hF7]}) begin
            cont_upd = 2'd3;
         end else begin
            utf8_upd = 1'b0;
         end
      end

      // EUC-KR pairing: lead byte must be followed by a trail byte
      trail_upd = trail_due_ff;
      pair_upd  = pair_ok_ff;
      if (pair_ok_ff) begin
         if (trail_due_ff) begin
            if (s1_byte_ff < EUC_TRAIL_MIN) begin
               pair_upd = 1'b0;
            end
            trail_upd = 1'b0;
         end else if (s1_byte_ff >= HIGH_BYTE_MIN) begin
            if (s1_byte_ff < EUC_LEAD_MIN) begin
               pair_upd = 1'b0;
            end else begin
               trail_upd = 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Classification on the final byte; BOM first, then the checks
   // ------------------------------------------------------------------
   assign b0 = head_upd[7:0];
   assign b1 = head_upd[15:8];
   assign b2 = head_upd[23:16];
   assign b3 = head_upd[31:24];

   always_comb begin
      if (seen_upd >= count_type'(3) && b0 == BOM_EF && b1 == BOM_BB && b2 == BOM_BF) begin
         code_now = CODE_UTF8;
      end else if (seen_upd >= COUNT_FULL && b0 == BOM_FF && b1 == BOM_FE
                   && b2 == BOM_00 && b3 == BOM_00) begin
         code_now = CODE_UTF32LE;
      end else if (seen_upd >= COUNT_FULL && b0 == BOM_00 && b1 == BOM_00
                   && b2 == BOM_FE && b3 == BOM_FF) begin
         code_now = CODE_UTF32BE;
      end else if (seen_upd >= count_type'(2) && b0 == BOM_FF && b1 == BOM_FE) begin
         code_now = CODE_UTF16LE;
      end else if (seen_upd >= count_type'(2) && b0 == BOM_FE && b1 == BOM_FF) begin
         code_now = CODE_UTF16BE;
      end else if (utf8_upd && cont_upd == 2'd0) begin
         code_now = CODE_UTF8;
      end else if (pair_upd && !trail_upd) begin
         code_now = CODE_EUCKR;
      end else begin
         code_now = CODE_SYSTEM;
      end
   end

   // ------------------------------------------------------------------
   // Next state: advance on each staged byte, clear at the end of a sample
   // ------------------------------------------------------------------
   always_comb begin
      head_in      = head_ff;
      seen_in      = seen_ff;
      cont_due_in  = cont_due_ff;
      utf8_ok_in   = utf8_ok_ff;
      trail_due_in = trail_due_ff;
      pair_ok_in   = pair_ok_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            head_in      = '0;
            seen_in      = '0;
            cont_due_in  = 2'd0;
            utf8_ok_in   = 1'b1;
            trail_due_in = 1'b0;
            pair_ok_in   = 1'b1;
         end else begin
            head_in      = head_upd;
            seen_in      = seen_upd;
            cont_due_in  = cont_upd;
            utf8_ok_in   = utf8_upd;
            trail_due_in = trail_upd;
            pair_ok_in   = pair_upd;
         end
      end
   end

   // Load a fresh word into the result register, or drop a taken one.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = code_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         seen_ff      <= '0;
         cont_due_ff  <= 2'd0;
         utf8_ok_ff   <= 1'b1;
         trail_due_ff <= 1'b0;
         pair_ok_ff   <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         seen_ff      <= seen_in;
         cont_due_ff  <= cont_due_in;
         utf8_ok_ff   <= utf8_ok_in;
         trail_due_ff <= trail_due_in;
         pair_ok_ff   <= pair_ok_in;
      end
   end

   // payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_end_of_sample;
      end
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_encoding_code = rsp_code_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> seen_ff == '0 && head_ff == '0 && utf8_ok_ff
         && pair_ok_ff && cont_due_ff == 2'd0 && !trail_due_ff)
      else $error("scan state not cleared after final byte");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= COUNT_FULL)
      else $error("byte count past saturation");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked final byte");

   a_word_from_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_last_ff && !(rsp_valid_ff && rsp_stall) |=> !rsp_valid_ff)
      else $error("result word from a middle byte");

endmodule

// ===== bench/text_encoding_detector_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_encoding_detector_checker: encoding code scoreboard
// Watches both channels, rebuilds the byte scan for every taken byte, queues
// the code due at each sample end and compares it with the returned codes.
// ----------------------------------------------------------------------------
module text_encoding_detector_checker import ted_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_sample,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_encoding_code,
   output int         error_count,
   output int         codes_outstanding
);

   localparam int ReportLimit = 10;

   // scan state of the sample in flight
   logic [HeadWidth-1:0] mark_window;
   count_type            window_fill;
   logic [1:0]           utf8_pending;
   logic                 utf8_ok;
   logic                 euc_trail_pending;
   logic                 euc_ok;

   code_type expected_codes[$];
   int       errors = 0;

   task automatic clear_scan();
      mark_window = '0;
      window_fill = '0;
      utf8_pending = '0;
      utf8_ok = 1'b1;
      euc_trail_pending = 1'b0;
      euc_ok = 1'b1;
   endtask

   task automatic note_mismatch(input string what, input string want, input code_type got);
      errors++;
      if (errors <= ReportLimit)
         $display("%0t: encoding code error (%s): expected %s, got %0d",
                  $time, what, want, got);
   endtask

   // A mark beats the structure checks; four-byte marks are tried before two-byte marks.
   function automatic code_type predict_encoding();
      byte_type m0, m1, m2, m3;
      m0 = mark_window[7:0];
      m1 = mark_window[15:8];
      m2 = mark_window[23:16];
      m3 = mark_window[31:24];
      if (window_fill >= 3 && m0 == BOM_EF && m1 == BOM_BB && m2 == BOM_BF)
         return CODE_UTF8;
      if (window_fill == COUNT_FULL) begin
         if (m0 == BOM_FF && m1 == BOM_FE && m2 == BOM_00 && m3 == BOM_00)
            return CODE_UTF32LE;
         if (m0 == BOM_00 && m1 == BOM_00 && m2 == BOM_FE && m3 == BOM_FF)
            return CODE_UTF32BE;
      end
      if (window_fill >= 2) begin
         if (m0 == BOM_FF && m1 == BOM_FE)
            return CODE_UTF16LE;
         if (m0 == BOM_FE && m1 == BOM_FF)
            return CODE_UTF16BE;
      end
      if (utf8_ok && utf8_pending == 0)
         return CODE_UTF8;
      if (euc_ok && !euc_trail_pending)
         return CODE_EUCKR;
      return CODE_SYSTEM;
   endfunction

   always @(posedge clock) begin
      byte_type b;
      code_type want;
      if (reset) begin
         clear_scan();
         expected_codes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               note_mismatch("no code pending", "none", rsp_encoding_code);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_encoding_code !== want)
                  note_mismatch("wrong code", $sformatf("%0d", want), rsp_encoding_code);
            end
         end
         if (req_valid && !req_stall) begin
            b = req_data_byte;
            if (window_fill < COUNT_FULL) begin
               mark_window[ByteWidth*window_fill +: ByteWidth] = b;
               window_fill = window_fill + 1'b1;
            end
            if (utf8_ok) begin
               if (utf8_pending != 0) begin
                  if (b[7:6] != 2'b10)
                     utf8_ok = 1'b0;
                  else
                     utf8_pending = utf8_pending - 1'b1;
               end else if (b[7]) begin
                  if (b[7:5] == 3'b110)
                     utf8_pending = 2'd1;
                  else if (b[7:4] == 4'b1110)
                     utf8_pending = 2'd2;
                  else if (b[7:3] == 5'b11110)
                     utf8_pending = 2'd3;
                  else
                     utf8_ok = 1'b0;
               end
            end
            if (euc_ok) begin
               if (euc_trail_pending) begin
                  if (b < EUC_TRAIL_MIN)
                     euc_ok = 1'b0;
                  euc_trail_pending = 1'b0;
               end else if (b >= HIGH_BYTE_MIN) begin
                  if (b < EUC_LEAD_MIN)
                     euc_ok = 1'b0;
                  else
                     euc_trail_pending = 1'b1;
               end
            end
            if (req_end_of_sample) begin
               expected_codes.push_back(predict_encoding());
               clear_scan();
            end
         end
      end
      error_count <= errors;
      codes_outstanding <= expected_codes.size();
   end

endmodule

// ===== bench/text_encoding_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_encoding_detector_tb: encoding detector testbench
// Feeds byte samples (marks, UTF-8 and EUC-KR text, broken and random bytes)
// with random gaps and result stalls; the checker scores every code.
// ----------------------------------------------------------------------------
module text_encoding_detector_tb import ted_pkg::*;;

   localparam int RandomWords = 1500;
   localparam int DrainCycles = 8;
   localparam int TimeoutNs   = 2_000_000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = '0;
   logic       req_end_of_sample = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_encoding_code;

   int error_count;
   int codes_outstanding;

   // calm stretches: both sides run with no gaps and no stalls
   logic calm = 1'b0;
   int   hold_left = 0;
   int   words_sent = 0;

   // bytes of the next sample, first byte at the front
   byte_type sample_bytes[$];

   text_encoding_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_sample (req_end_of_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_encoding_code (rsp_encoding_code)
   );

   text_encoding_detector_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_sample (req_end_of_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_encoding_code (rsp_encoding_code),
      .error_count       (error_count),
      .codes_outstanding (codes_outstanding)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: after each taken word, hold stall for a drawn number of
   // cycles, then drop it until the next word goes through.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            hold_left = calm ? 0 : $urandom_range(0, 5);
         else if (hold_left > 0)
            hold_left--;
         rsp_stall <= (hold_left > 0);
      end
   end

   // Offer one byte after a drawn gap and hold it until the block takes it.
   // Valid stays high between back-to-back words; it drops only for a gap.
   task automatic send_word(input byte_type b, input logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Send the queued sample, marking its final byte, and empty the queue.
   task automatic send_sample();
      for (int i = 0; i < sample_bytes.size(); i++)
         send_word(sample_bytes[i], i == sample_bytes.size() - 1);
      sample_bytes.delete();
   endtask

   // Append the leading count bytes of a packed word, high byte first.
   task automatic queue_packed(input logic [31:0] word, input int count);
      for (int i = 0; i < count; i++)
         sample_bytes.push_back(word[31 - 8*i -: 8]);
   endtask

   // Well-formed UTF-8 character of 1 to 4 bytes with random payload bits.
   task automatic add_utf8_char();
      int       n;
      byte_type r;
      n = $urandom_range(1, 4);
      r = byte_type'($urandom_range(0, 255));
      case (n)
         1: sample_bytes.push_back({1'b0, r[6:0]});
         2: sample_bytes.push_back({3'b110, r[4:0]});
         3: sample_bytes.push_back({4'b1110, r[3:0]});
         default: sample_bytes.push_back({5'b11110, r[2:0]});
      endcase
      repeat (n - 1) begin
         r = byte_type'($urandom_range(0, 255));
         sample_bytes.push_back({2'b10, r[5:0]});
      end
   endtask

   // Either a plain low byte or a legal lead/trail pair.
   task automatic add_euc_char();
      if ($urandom_range(0, 1)) begin
         sample_bytes.push_back(byte_type'($urandom_range(0, 127)));
      end else begin
         sample_bytes.push_back(byte_type'($urandom_range(EUC_LEAD_MIN, 255)));
         sample_bytes.push_back(byte_type'($urandom_range(EUC_TRAIL_MIN, 255)));
      end
   endtask

   // One of the five marks, now and then cut short.
   task automatic add_mark();
      logic [31:0] mark;
      int          mark_len;
      case ($urandom_range(0, 4))
         0: begin mark = {BOM_EF, BOM_BB, BOM_BF, BOM_00}; mark_len = 3; end
         1: begin mark = {BOM_FF, BOM_FE, BOM_00, BOM_00}; mark_len = 4; end
         2: begin mark = {BOM_00, BOM_00, BOM_FE, BOM_FF}; mark_len = 4; end
         3: begin mark = {BOM_FF, BOM_FE, BOM_00, BOM_00}; mark_len = 2; end
         default: begin mark = {BOM_FE, BOM_FF, BOM_00, BOM_00}; mark_len = 2; end
      endcase
      if ($urandom_range(0, 3) == 0)
         mark_len = $urandom_range(1, mark_len);
      queue_packed(mark, mark_len);
   endtask

   // Mostly well-formed text, some raw noise, some broken text.
   task automatic build_sample();
      int kind;
      int chars;
      kind = $urandom_range(0, 9);
      chars = $urandom_range(1, 6);
      if (kind == 7 || (kind < 4 && $urandom_range(0, 3) == 0))
         add_mark();
      case (kind)
         0, 1, 2, 3: repeat (chars) add_utf8_char();
         4, 5, 6: repeat (chars) add_euc_char();
         7, 8: repeat (chars) sample_bytes.push_back(byte_type'($urandom_range(0, 255)));
         default: begin
            if ($urandom_range(0, 1))
               repeat (chars) add_utf8_char();
            else
               repeat (chars) add_euc_char();
            // cut the tail off, or smash one byte
            if (sample_bytes.size() > 1 && $urandom_range(0, 1))
               sample_bytes.delete(sample_bytes.size() - 1);
            else
               sample_bytes[$urandom_range(0, sample_bytes.size() - 1)] =
                  byte_type'($urandom_range(0, 255));
         end
      endcase
   endtask

   initial begin
      int random_start;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: every mark, then the structure corner cases
      queue_packed({BOM_EF, BOM_BB, BOM_BF, BOM_00}, 3); send_sample();
      queue_packed({BOM_FF, BOM_FE, BOM_00, BOM_00}, 4); send_sample();
      queue_packed({BOM_00, BOM_00, BOM_FE, BOM_FF}, 4); send_sample();
      // UTF-32LE mark one byte short falls back to UTF-16LE
      queue_packed({BOM_FF, BOM_FE, BOM_00, BOM_00}, 3); send_sample();
      queue_packed({BOM_FF, BOM_FE, BOM_00, BOM_00}, 2); send_sample();
      queue_packed({BOM_FE, BOM_FF, BOM_00, BOM_00}, 2); send_sample();
      // one-byte samples: plain, lead 0x80, all ones
      queue_packed(32'h0000_0000, 1); send_sample();
      queue_packed(32'h8000_0000, 1); send_sample();
      queue_packed(32'hFF00_0000, 1); send_sample();
      // good EUC-KR pair, then a trail byte below the limit
      queue_packed(32'hB0A1_0000, 2); send_sample();
      queue_packed(32'h8140_0000, 2); send_sample();
      // sample ends mid UTF-8 sequence and on a lead byte
      queue_packed(32'hE000_0000, 1); send_sample();

      // random samples until the byte budget is spent
      random_start = words_sent;
      while (words_sent - random_start < RandomWords) begin
         if ($urandom_range(0, 29) == 0)
            calm <= ~calm;
         build_sample();
         send_sample();
      end
      req_valid <= 1'b0;

      // let the last push land in the checker, then drain
      @(posedge clock);
      while (codes_outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0 && codes_outstanding == 0)
         $display("text_encoding_detector: match");
      else
         $display("text_encoding_detector: mismatch");
      $finish;
   end

   // hard stop if the handshake hangs
   initial begin
      #(TimeoutNs);
      $display("text_encoding_detector: mismatch");
      $finish;
   end

endmodule
